>>> rtl/flat_face_normal_unit_defines.svh
// Assertion macros for the flat face normal unit.
`ifndef FLAT_FACE_NORMAL_UNIT_DEFINES_SVH
`define FLAT_FACE_NORMAL_UNIT_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define FFN_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FFN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFN_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FFN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/ffn_pkg.sv
// Shared constants and types of the flat face normal unit.
`default_nettype none
package ffn_pkg;
  localparam int SLOT_W           = 12;
  localparam int POS_W            = 16;
  localparam int NORM_W           = 16;
  localparam int FACE_W           = 16;
  localparam int DEF_VERTEX_DEPTH = 4096;
  localparam int DEF_COORD_WIDTH  = 16;
  localparam int ONE_Q14          = 16384;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_MESH = 2'd2;

  // Triangle waiting in the queue
  typedef struct packed {
    logic [SLOT_W-1:0] c0;
    logic [SLOT_W-1:0] c1;
    logic [SLOT_W-1:0] c2;
    logic [FACE_W-1:0] face;
  } tri_t;

  // Back part status seen by the front part
  typedef struct packed {
    logic pop;
    logic reading;
  } back_ctl_t;
endpackage
`default_nettype wire

>>> rtl/ffn_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/ffn_front.sv
// Front part: accepts items, writes vertices, numbers faces, queues triangles.
`default_nettype none
`include "flat_face_normal_unit_defines.svh"
module ffn_front #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_WIDTH  = 16,
  localparam int AW = $clog2(VERTEX_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        cmd,
  input  logic [ffn_pkg::SLOT_W-1:0]        vertex_slot,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_y,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_z,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner0,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner1,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner2,
  output logic                              we,
  output logic [AW-1:0]                     waddr,
  output logic [3*COORD_WIDTH-1:0]          wdata,
  output logic                              q_valid,
  output ffn_pkg::tri_t                     q_entry,
  input  ffn_pkg::back_ctl_t                ctl
);
  import ffn_pkg::*;

  tri_t              q_mem [2];
  logic              q_wp;
  logic              q_rp;
  logic [1:0]        q_cnt;
  logic [FACE_W-1:0] face_cnt;
  logic              q_empty;
  logic              q_full;
  logic              accept;
  logic              push;
  logic              slot_ok;

  assign q_empty = (q_cnt == 2'd0);
  assign q_full  = (q_cnt == 2'd2);
  assign slot_ok = (32'(vertex_slot) < 32'(VERTEX_DEPTH));

  // Hold loads back until older triangles have read their corners, and triangles while the queue is full
  always_comb begin
    case (cmd)
      CMD_LOAD: in_stall = !q_empty || ctl.reading;
      CMD_TRI:  in_stall = q_full;
      default:  in_stall = 1'b0;
    endcase
  end

  assign accept = in_valid && !in_stall;
  assign push   = accept && (cmd == CMD_TRI);

  // Vertex write
  assign we    = accept && (cmd == CMD_LOAD) && slot_ok;
  assign waddr = AW'(vertex_slot);
  assign wdata = {COORD_WIDTH'($unsigned(pos_z)), COORD_WIDTH'($unsigned(pos_y)),
                  COORD_WIDTH'($unsigned(pos_x))};

  // Queue pointers, fill and face counter
  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp     <= 1'b0;
      q_rp     <= 1'b0;
      q_cnt    <= 2'd0;
      face_cnt <= '0;
    end else begin
      if (push) begin
        q_wp     <= ~q_wp;
        face_cnt <= face_cnt + FACE_W'(1);
      end
      if (accept && (cmd == CMD_MESH)) face_cnt <= '0;
      if (ctl.pop) q_rp <= ~q_rp;
      case ({push, ctl.pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[q_wp] <= '{c0: corner0, c1: corner1, c2: corner2, face: face_cnt};
  end

  assign q_valid = !q_empty;
  assign q_entry = q_mem[q_rp];

  `FFN_ASSERT_IMPL(a_load_order, clk, rst, we, q_empty && !ctl.reading, "load overtook a triangle")
  `FFN_ASSERT_NEXT(a_face_adv, clk, rst, push, face_cnt == $past(face_cnt) + FACE_W'(1), "face count")
  `FFN_ASSERT_IMPL(a_pop_nonempty, clk, rst, ctl.pop, !q_empty, "pop from empty queue")
endmodule
`default_nettype wire

>>> rtl/ffn_back.sv
// Back part: corner fetch, cross product, normalisation and result register.
`default_nettype none
`include "flat_face_normal_unit_defines.svh"
module ffn_back #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_WIDTH  = 16,
  localparam int AW = $clog2(VERTEX_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  ffn_pkg::tri_t                     q_entry,
  output ffn_pkg::back_ctl_t                ctl,
  output logic                              re,
  output logic [AW-1:0]                     raddr,
  input  logic [3*COORD_WIDTH-1:0]          rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_x,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_y,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_z,
  output logic [ffn_pkg::FACE_W-1:0]        normal_slot,
  output logic                              degenerate
);
  import ffn_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int MW = PW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_R1, S_R2, S_R3, S_MUL, S_MAG, S_SHIFT, S_SQ, S_SQRT, S_DINIT, S_DIV, S_FIN
  } state_t;

  state_t                 state;
  tri_t                   cur;
  logic [SLOT_W-1:0]      rslot;
  logic                   rd_ok;
  logic signed [CW-1:0]   rd_c [3];
  logic signed [CW-1:0]   p0 [3];
  logic signed [DW-1:0]   a [3];
  logic signed [DW-1:0]   b [3];
  logic signed [DW-1:0]   mx;
  logic signed [DW-1:0]   my;
  logic signed [PW-1:0]   prod;
  logic signed [MW-1:0]   c [3];
  logic [2:0]             mcnt;
  logic [2:0]             kk;
  logic [MW-1:0]          m [3];
  logic [30:0]            mm [3];
  logic                   neg [3];
  logic                   big;
  logic [30:0]            sq_op;
  logic [61:0]            sq;
  logic [63:0]            s_acc;
  logic [63:0]            v;
  logic [63:0]            r;
  logic [63:0]            sbit;
  logic [63:0]            t;
  logic [4:0]             scnt;
  logic [1:0]             dj;
  logic [3:0]             dstep;
  logic [47:0]            rem;
  logic [47:0]            dsh;
  logic                   ge;
  logic [15:0]            q;
  logic [15:0]            q_next;
  logic [15:0]            nq;
  logic [NORM_W-1:0]      nrm [3];
  logic                   deg;

  // Corner read address
  always_comb begin
    case (state)
      S_R1:    rslot = cur.c1;
      S_R2:    rslot = cur.c2;
      default: rslot = q_entry.c0;
    endcase
  end

  assign ctl.pop     = (state == S_IDLE) && q_valid;
  assign ctl.reading = (state == S_R1) || (state == S_R2);
  assign re          = ctl.pop || ctl.reading;
  assign raddr       = AW'(rslot);

  // Unpack corner, zero for a slot beyond the store
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_c[i] = rd_ok ? $signed(rdata[i*CW +: CW]) : '0;
    end
  end

  // Cross product operand select
  assign kk = mcnt - 3'd1;
  always_comb begin
    case (mcnt)
      3'd0:    begin mx = a[1]; my = b[2]; end
      3'd1:    begin mx = a[2]; my = b[1]; end
      3'd2:    begin mx = a[2]; my = b[0]; end
      3'd3:    begin mx = a[0]; my = b[2]; end
      3'd4:    begin mx = a[0]; my = b[1]; end
      default: begin mx = a[1]; my = b[0]; end
    endcase
  end

  // Magnitudes limited to 31 bits
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mm[i] = 31'(m[i]);
      big   = big || ((m[i] >> 31) != '0);
    end
  end

  always_comb begin
    case (mcnt)
      3'd0:    sq_op = mm[0];
      3'd1:    sq_op = mm[1];
      default: sq_op = mm[2];
    endcase
  end

  // Square-root step and division step
  assign t      = r + sbit;
  assign ge     = (rem >= dsh);
  assign q_next = {q[14:0], ge};
  assign nq     = (q_next > 16'(ONE_Q14)) ? 16'(ONE_Q14) : q_next;

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise the result on completion, drop it once taken
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (re) rd_ok <= (32'(rslot) < 32'(VERTEX_DEPTH));
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_entry;
            state <= S_R1;
          end
        end
        S_R1: begin
          p0    <= rd_c;
          state <= S_R2;
        end
        S_R2: begin
          for (int i = 0; i < 3; i++) a[i] <= {p0[i][CW-1], p0[i]} - {rd_c[i][CW-1], rd_c[i]};
          state <= S_R3;
        end
        S_R3: begin
          for (int i = 0; i < 3; i++) b[i] <= {p0[i][CW-1], p0[i]} - {rd_c[i][CW-1], rd_c[i]};
          mcnt  <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= mx * my;
          if (mcnt != 3'd0) begin
            c[kk[2:1]] <= kk[0] ? (c[kk[2:1]] - {prod[PW-1], prod}) : {prod[PW-1], prod};
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd6) state <= S_MAG;
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= c[i][MW-1];
            m[i]   <= c[i][MW-1] ? MW'(-c[i]) : MW'(c[i]);
          end
          if (c[0] == '0 && c[1] == '0 && c[2] == '0) begin
            deg <= 1'b1;
            for (int i = 0; i < 3; i++) nrm[i] <= '0;
            state <= S_FIN;
          end else begin
            deg   <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else begin
            mcnt  <= 3'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= sq_op * sq_op;
          if (mcnt != 3'd0) s_acc <= ((mcnt == 3'd1) ? 64'd0 : s_acc) + 64'(sq);
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd3) begin
            v     <= ((mcnt == 3'd1) ? 64'd0 : s_acc) + 64'(sq);
            r     <= 64'd0;
            sbit  <= 64'h4000_0000_0000_0000;
            scnt  <= 5'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (v >= t) begin
            v <= v - t;
            r <= (r >> 1) + sbit;
          end else begin
            r <= r >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd31) begin
            dj    <= 2'd0;
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          rem   <= 48'({mm[dj], 14'd0}) + 48'(r[31:1]);
          dsh   <= {1'b0, r[31:0], 15'd0};
          q     <= 16'd0;
          dstep <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (ge) rem <= rem - dsh;
          dsh   <= dsh >> 1;
          q     <= q_next;
          dstep <= dstep + 4'd1;
          if (dstep == 4'd15) begin
            nrm[dj] <= neg[dj] ? (16'd0 - nq) : nq;
            if (dj == 2'd2) begin
              state <= S_FIN;
            end else begin
              dj    <= dj + 2'd1;
              state <= S_DINIT;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            normal_x    <= nrm[0];
            normal_y    <= nrm[1];
            normal_z    <= nrm[2];
            normal_slot <= cur.face;
            degenerate  <= deg;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFN_ASSERT_IMPL(a_deg_zero, clk, rst, out_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate normal not zero")
  `FFN_ASSERT_IMPL(a_unit_range, clk, rst, out_valid && !degenerate, normal_x <= 16384 && normal_x >= -16384, "normal out of range")
  `FFN_ASSERT_NEXT(a_fin_hold, clk, rst, state == S_FIN && out_valid && out_stall, state == S_FIN, "result lost under stall")
endmodule
`default_nettype wire

>>> rtl/flat_face_normal_unit.sv
// Top level of the flat face normal unit.
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid, in_stall  | cmd, vertex_slot, pos_x/y/z, corner0/1/2
//  out     | from block| out_valid, out_stall| normal_x/y/z, normal_slot, degenerate
//
// A start-mesh item is never held back; a load waits while triangles are queued
// or their corners are being read.
// A triangle passes through three corner reads, six multiplies, a normalising shift,
// 32 square-root steps and 3 x 17 divide steps.
// A degenerate triangle skips the shift, square root and divide. Up to two triangles queue ahead of the back part.
// Reset clears the queue, the face counter and the sequencer; the vertex store is not cleared.
// A stalled result holds in the output register while the front keeps accepting items until the queue is full.
`default_nettype none
module flat_face_normal_unit #(
  parameter int VERTEX_DEPTH = ffn_pkg::DEF_VERTEX_DEPTH,
  parameter int COORD_WIDTH  = ffn_pkg::DEF_COORD_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        cmd,
  input  logic [ffn_pkg::SLOT_W-1:0]        vertex_slot,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_x,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_y,
  input  logic signed [ffn_pkg::POS_W-1:0]  pos_z,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner0,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner1,
  input  logic [ffn_pkg::SLOT_W-1:0]        corner2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_x,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_y,
  output logic signed [ffn_pkg::NORM_W-1:0] normal_z,
  output logic [ffn_pkg::FACE_W-1:0]        normal_slot,
  output logic                              degenerate
);
  import ffn_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [3*COORD_WIDTH-1:0] wdata;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [3*COORD_WIDTH-1:0] rdata;
  logic                     q_valid;
  tri_t                     q_entry;
  back_ctl_t                ctl;

  ffn_front #(.VERTEX_DEPTH(VERTEX_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .vertex_slot, .pos_x, .pos_y, .pos_z,
    .corner0, .corner1, .corner2, .we, .waddr, .wdata, .q_valid, .q_entry, .ctl
  );

  ffn_ram #(.WIDTH(3*COORD_WIDTH), .DEPTH(VERTEX_DEPTH)) u_store (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  ffn_back #(.VERTEX_DEPTH(VERTEX_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_entry, .ctl, .re, .raddr, .rdata, .out_valid, .out_stall,
    .normal_x, .normal_y, .normal_z, .normal_slot, .degenerate
  );
endmodule
`default_nettype wire
